@@ rtl/rgb_to_hsi_pixel_defines.svh @@
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter: assertion macros
// Assertion helpers shared by the files of the converter. In synthesis they
// expand to nothing.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSI_PIXEL_DEFINES_SVH
`define RGB_TO_HSI_PIXEL_DEFINES_SVH

`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define HSI_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rgb_to_hsi_pixel: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define HSI_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rgb_to_hsi_pixel: next-cycle check failed");
`else
`define HSI_ASSERT_IMP(label, ante, cons)
`define HSI_ASSERT_NXT(label, ante, cons)
`endif

`endif

@@ rtl/hsi_pkg.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter: package
// Widths, stage counts, the control struct and the two constant tables
// (squared cosine thresholds and saturation tie results), built at elaboration.
// ----------------------------------------------------------------------------
package hsi_pkg;

	// Datapath widths.
	localparam int USQ_W   = 18;  // (2R-G-B)^2
	localparam int D4_W    = 18;  // 4*((R-G)^2+(R-B)(G-B))
	localparam int COS_W   = 44;  // cos^2 threshold, unsigned Q44
	localparam int PROD_W  = D4_W + COS_W;
	localparam int IDX_W   = 6;   // threshold index
	localparam int NUM_W   = 19;  // 510*(sum-3*min)
	localparam int SUM_W   = 10;
	localparam int SAT_Q_W = 9;   // quotient of 510*t/sum

	// Pipeline shape.
	localparam int HUE_STEPS      = IDX_W;
	localparam int HUE_STAGES     = 2 * HUE_STEPS;
	localparam int SAT_DIV_STAGES = 3;
	localparam int SAT_BITS_STG   = SAT_Q_W / SAT_DIV_STAGES;
	localparam int SAT_STAGES     = SAT_DIV_STAGES + 1;
	localparam int PIPE_STAGES    = HUE_STAGES + 2;
	// Extra stages that line saturation up with the hue search.
	localparam int SAT_DLY        = HUE_STAGES - SAT_STAGES;

	localparam logic [63:0] Q60_ONE  = 64'd1 << 60;
	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	// pi/254 in Q60, split into the whole step and the leftover numerator.
	localparam logic [63:0] COS_STEP = PI_Q60 / 64'd254;
	localparam logic [63:0] COS_FRAC = PI_Q60 % 64'd254;

	// Control that travels with an item through the hue search.
	typedef struct packed {
		logic gray;   // R = G = B
		logic ge;     // green >= blue
		logic uneg;   // 2R-G-B < 0
		logic uzero;  // 2R-G-B = 0
	} hue_ctrl_t;

	typedef logic [63:0][COS_W-1:0] cos_tab_t;
	typedef logic [255:0][7:0] sat_tab_t;

	// Q60 product, keeping bits 123 down to 60.
	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Unsigned quotient by long division, used only while the tables are built.
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] dv);
		logic [64:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], n[i]};
			if (rem >= {1'b0, dv}) begin
				rem = rem - {1'b0, dv};
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// cos^2 at the angles (2j-1)*pi/254 by a Taylor series in Q60.
	function automatic cos_tab_t build_cos_tab();
		cos_tab_t tab;
		logic [63:0] m, ang, a2, t, d, c;
		tab = '0;
		for (int j = 1; j < 64; j++) begin
			m = 64'(2 * j - 1);
			ang = COS_STEP * m + udiv64(COS_FRAC * m, 64'd254);
			a2 = mul_q60(ang, ang);
			t = Q60_ONE;
			for (int n = 13; n >= 1; n--) begin
				d = 64'((2 * n - 1) * (2 * n));
				t = Q60_ONE - udiv64(mul_q60(a2, t), d);
			end
			c = (mul_q60(t, t) + (64'd1 << 15)) >> 16;
			tab[j] = c[COS_W-1:0];
		end
		return tab;
	endfunction

	// Round to a 53-bit significand, ties to even.
	function automatic logic [63:0] round53(logic [63:0] m);
		int len;
		int sh;
		logic [63:0] low, half, top, mask;
		len = 0;
		for (int i = 0; i < 64; i++) begin
			if (m[i]) len = i + 1;
		end
		if (len <= 53) return m;
		sh = len - 53;
		mask = (64'd1 << sh) - 64'd1;
		low = m & mask;
		half = 64'd1 << (sh - 1);
		top = m >> sh;
		if (low > half || (low == half && top[0])) top = top + 64'd1;
		return top << sh;
	endfunction

	// Saturation as the double-precision steps give it.
	function automatic logic [7:0] sat_double(logic [63:0] n3min, logic [63:0] sum);
		logic [63:0] rem, quo, q, s, p;
		int k;
		if (n3min == 64'd0) return 8'd255;
		rem = n3min;
		quo = 64'd0;
		for (int i = 0; i < 63; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= sum) begin
				rem = rem - sum;
				quo = quo | 64'd1;
			end
		end
		if (rem != 64'd0) quo = quo | 64'd1;
		q = round53(quo);
		s = round53((64'd1 << 63) - q);
		k = 63;
		for (int i = 0; i < 64; i++) begin
			if (s != 64'd0 && !s[0] && k > 0) begin
				s = s >> 1;
				k = k - 1;
			end
		end
		p = round53(s * 64'd255);
		if (k == 0) return p[7:0];
		p = (p + (64'd1 << (k - 1))) >> k;
		return p[7:0];
	endfunction

	// Results for exact ties, indexed by the odd quotient Q shifted right by one.
	function automatic sat_tab_t build_sat_tab();
		sat_tab_t tab;
		tab = '0;
		for (int i = 0; i < 255; i++) begin
			tab[i] = sat_double(64'(510 - (2 * i + 1)), 64'd510);
		end
		return tab;
	endfunction

	localparam cos_tab_t COS_SQ  = build_cos_tab();
	localparam sat_tab_t SAT_TIE = build_sat_tab();

endpackage

@@ rtl/hsi_hue_search.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter: hue threshold search
// Binary search over the monotone cos^2 thresholds, one index bit per step,
// each step a multiply stage followed by a compare stage.
// ----------------------------------------------------------------------------
module hsi_hue_search
	import hsi_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [USQ_W-1:0] usq,
	input  logic [D4_W-1:0]  d4,
	input  hue_ctrl_t        ctrl_in,
	output logic [IDX_W-1:0] cnt,
	output hue_ctrl_t        ctrl_out
);

	logic [IDX_W-1:0]  n_s1    [HUE_STEPS];
	logic [IDX_W-1:0]  cand_s1 [HUE_STEPS];
	logic [PROD_W-1:0] prod_s1 [HUE_STEPS];
	logic [USQ_W-1:0]  usq_s1  [HUE_STEPS];
	logic [D4_W-1:0]   d4_s1   [HUE_STEPS];
	hue_ctrl_t         ctrl_s1 [HUE_STEPS];

	logic [IDX_W-1:0]  n_s2    [HUE_STEPS];
	logic [USQ_W-1:0]  usq_s2  [HUE_STEPS];
	logic [D4_W-1:0]   d4_s2   [HUE_STEPS];
	hue_ctrl_t         ctrl_s2 [HUE_STEPS];

	for (genvar k = 0; k < HUE_STEPS; k++) begin : g_step
		logic [IDX_W-1:0]  n_prev;
		logic [IDX_W-1:0]  cand;
		logic [USQ_W-1:0]  usq_prev;
		logic [D4_W-1:0]   d4_prev;
		hue_ctrl_t         ctrl_prev;
		logic [PROD_W-1:0] lhs;
		logic              pass;

		// Each step takes the partial index from the step before.
		if (k == 0) begin : g_first
			assign n_prev    = '0;
			assign usq_prev  = usq;
			assign d4_prev   = d4;
			assign ctrl_prev = ctrl_in;
		end else begin : g_next
			assign n_prev    = n_s2[k-1];
			assign usq_prev  = usq_s2[k-1];
			assign d4_prev   = d4_s2[k-1];
			assign ctrl_prev = ctrl_s2[k-1];
		end

		// Try the next index bit and scale its threshold by 4D.
		assign cand = n_prev | (IDX_W'(1) << (HUE_STEPS - 1 - k));

		always_ff @(posedge clk) begin
			if (en) begin
				n_s1[k]    <= n_prev;
				cand_s1[k] <= cand;
				prod_s1[k] <= {{COS_W{1'b0}}, d4_prev} * {{D4_W{1'b0}}, COS_SQ[cand]};
				usq_s1[k]  <= usq_prev;
				d4_s1[k]   <= d4_prev;
				ctrl_s1[k] <= ctrl_prev;
			end
		end

		// The angle reaches the threshold when u^2 stays under 4D*cos^2; a
		// negative u counts the thresholds it falls short of, with a strict test.
		assign lhs  = {usq_s1[k], {COS_W{1'b0}}};
		assign pass = ctrl_s1[k].uneg ? (lhs < prod_s1[k]) : (lhs <= prod_s1[k]);

		always_ff @(posedge clk) begin
			if (en) begin
				n_s2[k]    <= pass ? cand_s1[k] : n_s1[k];
				usq_s2[k]  <= usq_s1[k];
				d4_s2[k]   <= d4_s1[k];
				ctrl_s2[k] <= ctrl_s1[k];
			end
		end
	end

	assign cnt      = n_s2[HUE_STEPS-1];
	assign ctrl_out = ctrl_s2[HUE_STEPS-1];

endmodule

@@ rtl/hsi_sat_div.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter: saturation divider
// Restoring division of 510*(sum-3*min) by the sum, three quotient bits per
// stage, then a rounding stage that matches double-precision ties.
// ----------------------------------------------------------------------------
module hsi_sat_div
	import hsi_pkg::*;
(
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [SUM_W-1:0] sum,
	output logic [7:0]       sat
);

	logic [NUM_W-1:0]   rem_s [SAT_DIV_STAGES];
	logic [SAT_Q_W-1:0] quo_s [SAT_DIV_STAGES];
	logic [SUM_W-1:0]   sum_s [SAT_DIV_STAGES];
	logic [7:0]         sat_s4;

	for (genvar s = 0; s < SAT_DIV_STAGES; s++) begin : g_div
		logic [NUM_W-1:0]   rem_prev;
		logic [SAT_Q_W-1:0] quo_prev;
		logic [SUM_W-1:0]   sum_prev;
		logic [NUM_W-1:0]   r;
		logic [NUM_W-1:0]   dvs;
		logic [SAT_Q_W-1:0] qv;

		if (s == 0) begin : g_first
			assign rem_prev = num;
			assign quo_prev = '0;
			assign sum_prev = sum;
		end else begin : g_next
			assign rem_prev = rem_s[s-1];
			assign quo_prev = quo_s[s-1];
			assign sum_prev = sum_s[s-1];
		end

		// A few subtract-and-compare steps, from the top quotient bit down.
		always_comb begin
			r = rem_prev;
			qv = quo_prev;
			dvs = '0;
			for (int i = 0; i < SAT_BITS_STG; i++) begin
				dvs = NUM_W'(sum_prev) << (SAT_Q_W - 1 - SAT_BITS_STG * s - i);
				if (r >= dvs) begin
					r = r - dvs;
					qv = {qv[SAT_Q_W-2:0], 1'b1};
				end else begin
					qv = {qv[SAT_Q_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s] <= r;
				quo_s[s] <= qv;
				sum_s[s] <= sum_prev;
			end
		end
	end

	// Round Q/2: an even Q is exact, an odd Q with a remainder rounds up, and
	// an exact half takes the tie table.
	logic [SAT_Q_W-1:0] q_fin;
	logic [SAT_Q_W:0]   q_up;
	logic [7:0]         sat_d;

	assign q_fin = quo_s[SAT_DIV_STAGES-1];
	assign q_up  = ({1'b0, q_fin} + (SAT_Q_W + 1)'(1)) >> 1;

	always_comb begin
		if (!q_fin[0]) begin
			sat_d = q_fin[SAT_Q_W-1:1];
		end else if (rem_s[SAT_DIV_STAGES-1] != '0) begin
			sat_d = q_up[7:0];
		end else begin
			sat_d = SAT_TIE[q_fin[SAT_Q_W-1:1]];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s4 <= sat_d;
		end
	end

	assign sat = sat_s4;

endmodule

@@ rtl/rgb_to_hsi_pixel.sv @@
// ----------------------------------------------------------------------------
// RGB to HSI pixel converter: top level
// Streams 8-bit RGB pixels in and 8-bit hue, saturation and intensity out.
// ----------------------------------------------------------------------------
// The block takes one pixel in every clock as long as no result waits at the
// output. Each pixel passes the input stage, then the hue search, which resolves six
// threshold index bits in two stages each (a multiply, then a compare), and
// then the output register. The whole pipeline advances whenever the output
// register is empty or being taken, so s_tready falls only while a result
// waits. Gray pixels give hue 0 and saturation 0.
// ----------------------------------------------------------------------------
`include "rgb_to_hsi_pixel_defines.svh"

module rgb_to_hsi_pixel
	import hsi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red [7:0], green [15:8], blue [23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // hue [7:0], saturation [15:8], intensity [23:16]
);

	logic [PIPE_STAGES-1:0] vld_q;
	logic                   stage_en;

	// Whole-pipeline advance.
	assign stage_en = !vld_q[PIPE_STAGES-1] || m_tready;
	assign s_tready = stage_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (stage_en) begin
			vld_q <= {vld_q[PIPE_STAGES-2:0], s_tvalid};
		end
	end

	// Input stage: sums, differences and the squared terms.
	logic [7:0]        red, green, blue;
	logic [SUM_W-1:0]  sum, t_val;
	logic [7:0]        mn;
	logic signed [10:0] u;
	logic signed [21:0] u_sq;
	logic signed [8:0] d_rg, d_rb, d_gb;
	logic signed [18:0] d_val;
	logic [26:0]       int_prod;
	logic [NUM_W-1:0]  num;
	hue_ctrl_t         ctrl_d;

	assign red   = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign blue  = s_tdata[23:16];

	assign sum = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);

	always_comb begin
		mn = (red < green) ? red : green;
		if (blue < mn) mn = blue;
	end

	assign t_val    = sum - SUM_W'(mn) * SUM_W'(3);
	assign num      = NUM_W'(t_val) * NUM_W'(510);
	assign int_prod = 27'(sum) * 27'd43691;

	assign u    = $signed({2'b00, red, 1'b0}) - $signed({3'b000, green})
		- $signed({3'b000, blue});
	assign u_sq = 22'(u) * 22'(u);
	assign d_rg = $signed({1'b0, red}) - $signed({1'b0, green});
	assign d_rb = $signed({1'b0, red}) - $signed({1'b0, blue});
	assign d_gb = $signed({1'b0, green}) - $signed({1'b0, blue});
	assign d_val = 19'(d_rg) * 19'(d_rg) + 19'(d_rb) * 19'(d_gb);

	assign ctrl_d.gray  = (red == green) && (green == blue);
	assign ctrl_d.ge    = (green >= blue);
	assign ctrl_d.uneg  = (u < 0);
	assign ctrl_d.uzero = (u == 0);

	logic [USQ_W-1:0] usq_s1;
	logic [D4_W-1:0]  d4_s1;
	hue_ctrl_t        ctrl_s1;
	logic [NUM_W-1:0] num_s1;
	logic [SUM_W-1:0] sum_s1;
	logic [7:0]       int_s1;

	always_ff @(posedge clk) begin
		if (stage_en) begin
			usq_s1  <= u_sq[USQ_W-1:0];
			d4_s1   <= {d_val[15:0], 2'b00};
			ctrl_s1 <= ctrl_d;
			num_s1  <= num;
			sum_s1  <= sum;
			int_s1  <= int_prod[24:17];
		end
	end

	// Hue search and saturation divider run side by side.
	logic [IDX_W-1:0] hue_cnt;
	hue_ctrl_t        hue_ctrl;
	logic [7:0]       sat_div;

	hsi_hue_search u_hue (
		.clk      (clk),
		.en       (stage_en),
		.usq      (usq_s1),
		.d4       (d4_s1),
		.ctrl_in  (ctrl_s1),
		.cnt      (hue_cnt),
		.ctrl_out (hue_ctrl)
	);

	hsi_sat_div u_sat (
		.clk (clk),
		.en  (stage_en),
		.num (num_s1),
		.sum (sum_s1),
		.sat (sat_div)
	);

	// Delay saturation and intensity to line up with the hue search.
	logic [7:0] sat_dly_q [SAT_DLY];
	logic [7:0] int_dly_q [HUE_STAGES];

	always_ff @(posedge clk) begin
		if (stage_en) begin
			sat_dly_q[0] <= sat_div;
			for (int i = 1; i < SAT_DLY; i++) sat_dly_q[i] <= sat_dly_q[i-1];
			int_dly_q[0] <= int_s1;
			for (int i = 1; i < HUE_STAGES; i++) int_dly_q[i] <= int_dly_q[i-1];
		end
	end

	// Turn the threshold count into the hue code.
	logic [7:0] cnt_full, hue_d;

	always_comb begin
		if (hue_ctrl.uneg) begin
			cnt_full = 8'd127 - {2'b00, hue_cnt};
		end else begin
			cnt_full = {2'b00, hue_cnt} + {7'd0, hue_ctrl.uzero & hue_ctrl.ge};
		end
		if (hue_ctrl.gray) begin
			hue_d = 8'd0;
		end else if (hue_ctrl.ge) begin
			hue_d = cnt_full + 8'd1;
		end else begin
			hue_d = 8'd255 - cnt_full;
		end
	end

	// Output register.
	logic [7:0] hue_q, sat_q, int_q;

	always_ff @(posedge clk) begin
		if (stage_en) begin
			hue_q <= hue_d;
			sat_q <= hue_ctrl.gray ? 8'd0 : sat_dly_q[SAT_DLY-1];
			int_q <= int_dly_q[HUE_STAGES-1];
		end
	end

	assign m_tvalid = vld_q[PIPE_STAGES-1];
	assign m_tdata  = {int_q, sat_q, hue_q};

	// Only a gray pixel has hue zero, and it carries zero saturation too.
	`HSI_ASSERT_IMP(a_gray_sat_zero, m_tvalid && hue_q == 8'd0, sat_q == 8'd0)
	// A stalled pipeline keeps every stage's valid bit.
	`HSI_ASSERT_NXT(a_stall_holds, !stage_en, $stable(vld_q))
	// An accepted item occupies the first stage in the next cycle.
	`HSI_ASSERT_NXT(a_accept_enters, s_tvalid && s_tready, vld_q[0])

endmodule

@@ dv/tb_rgb_to_hsi_pixel.sv @@
// ----------------------------------------------------------------------------
// Testbench for the RGB to HSI pixel converter
// Streams directed and random pixels through the block with random gaps and
// output stalls. A local model predicts hue, saturation and intensity for
// every accepted pixel, and each result item is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rgb_to_hsi_pixel;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

	typedef struct packed {
		logic [7:0] intensity;
		logic [7:0] saturation;
		logic [7:0] hue;
	} hsi_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	pixel_t      pixel_q[$];
	hsi_t        hsi_q[$];
	logic [63:0] cos_sq[64];
	int          idle_pct;
	logic        drain_hold;
	logic        taken;
	int          errors;

	rgb_to_hsi_pixel dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// Clock.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Q60 fixed-point product.
	function automatic logic [63:0] q60_mul(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// Squared cosine thresholds at (2j-1)*pi/254, unsigned Q44.
	task automatic fill_cos_sq();
		logic [63:0] pi_q60, one, step, frac, ang, a2, t;
		pi_q60 = 64'h3243F6A8885A308D;
		one = 64'd1 << 60;
		step = pi_q60 / 64'd254;
		frac = pi_q60 % 64'd254;
		cos_sq[0] = '0;
		for (int j = 1; j < 64; j++) begin
			ang = step * 64'(2 * j - 1) + (frac * 64'(2 * j - 1)) / 64'd254;
			a2 = q60_mul(ang, ang);
			t = one;
			for (int n = 13; n >= 1; n--)
				t = one - q60_mul(a2, t) / 64'((2 * n - 1) * (2 * n));
			cos_sq[j] = (q60_mul(t, t) + (64'd1 << 15)) >> 16;
		end
	endtask

	// Rounds to a 53-bit significand, ties to even.
	function automatic logic [63:0] to_double_bits(logic [63:0] m);
		int len;
		int sh;
		logic [63:0] low, half, top;
		len = 0;
		for (int i = 0; i < 64; i++)
			if (m[i]) len = i + 1;
		if (len <= 53) return m;
		sh = len - 53;
		low = m & ((64'd1 << sh) - 64'd1);
		half = 64'd1 << (sh - 1);
		top = m >> sh;
		if (low > half || (low == half && top[0])) top = top + 64'd1;
		return top << sh;
	endfunction

	// Saturation following double-precision arithmetic step by step.
	function automatic logic [7:0] sat_of(logic [63:0] n3min, logic [63:0] sum);
		logic [63:0] rem, quo, s, p;
		int k;
		if (n3min == 0) return 8'd255;
		rem = n3min;
		quo = '0;
		for (int i = 0; i < 63; i++) begin
			rem = rem << 1;
			quo = quo << 1;
			if (rem >= sum) begin
				rem = rem - sum;
				quo[0] = 1'b1;
			end
		end
		if (rem != 0) quo[0] = 1'b1;
		s = to_double_bits((64'd1 << 63) - to_double_bits(quo));
		k = 63;
		while (s != 0 && !s[0] && k > 0) begin
			s = s >> 1;
			k--;
		end
		p = to_double_bits(s * 64'd255);
		if (k == 0) return p[7:0];
		p = (p + (64'd1 << (k - 1))) >> k;
		return p[7:0];
	endfunction

	// Expected HSI result for one pixel.
	function automatic hsi_t convert_pixel(pixel_t px);
		hsi_t o;
		int r, g, b, mn, u, d, cnt;
		logic [63:0] lhs, rhs;
		r = px.red;
		g = px.green;
		b = px.blue;
		o = '0;
		o.intensity = 8'((r + g + b) / 3);
		if (!(r == g && g == b)) begin
			mn = (r < g) ? r : g;
			if (b < mn) mn = b;
			o.saturation = sat_of(64'(3 * mn), 64'(r + g + b));
			u = 2 * r - g - b;
			d = (r - g) * (r - g) + (r - b) * (g - b);
			lhs = 64'(u * u) << 44;
			rhs = 64'(4 * d);
			cnt = 0;
			for (int j = 1; j < 64; j++)
				if (u <= 0 || lhs <= rhs * cos_sq[j]) cnt++;
			if (g >= b ? (u <= 0) : (u < 0)) cnt++;
			for (int j = 1; j < 64; j++)
				if (u < 0 && lhs >= rhs * cos_sq[j]) cnt++;
			o.hue = (g >= b) ? 8'(1 + cnt) : 8'(255 - cnt);
		end
		return o;
	endfunction

	// Appends one pixel to the pending queue.
	task automatic add_pixel(pixel_t px);
		pixel_q = {pixel_q, px};
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch in %s: got %0d, expected %0d", what, got, want);
		errors++;
	endtask

	// Input acceptance: record the expectation and retire the pixel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				hsi_q = {hsi_q, convert_pixel(pixel_t'(s_tdata))};
				void'(pixel_q.pop_front());
			end
		end
	end

	// Driver: offers the next pending pixel on the falling edge.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || taken)) begin
			if (pixel_q.size() == 0 || drain_hold ||
			    $urandom_range(99) < idle_pct) begin
				s_tvalid <= 1'b0;
			end else begin
				s_tvalid <= 1'b1;
				s_tdata  <= pixel_q[0];
			end
		end
	end

	// Result side: random stalls and a field-by-field check.
	always @(negedge clk) begin
		if (arst_n) m_tready <= ($urandom_range(99) >= idle_pct);
	end

	always @(posedge clk) begin
		hsi_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = hsi_t'(m_tdata);
			if (hsi_q.size() == 0) begin
				$display("result item with no pixel outstanding: %h", m_tdata);
				errors++;
			end else begin
				want = hsi_q.pop_front();
				if (got.hue != want.hue) report("hue", got.hue, want.hue);
				if (got.saturation != want.saturation)
					report("saturation", got.saturation, want.saturation);
				if (got.intensity != want.intensity)
					report("intensity", got.intensity, want.intensity);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		pixel_t px;
		int kind;
		errors = 0;
		idle_pct = 8;
		drain_hold = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		fill_cos_sq();

		// Directed pixels: corners, gray, zero minimum and right-angle hue.
		add_pixel('{8'd0, 8'd0, 8'd0});
		add_pixel('{8'd255, 8'd255, 8'd255});
		add_pixel('{8'd128, 8'd128, 8'd128});
		add_pixel('{8'd0, 8'd0, 8'd255});
		add_pixel('{8'd0, 8'd255, 8'd0});
		add_pixel('{8'd255, 8'd0, 8'd0});
		add_pixel('{8'd0, 8'd255, 8'd255});
		add_pixel('{8'd255, 8'd255, 8'd0});
		add_pixel('{8'd255, 8'd0, 8'd255});
		add_pixel('{8'd3, 8'd2, 8'd1});
		add_pixel('{8'd100, 8'd100, 8'd200});
		add_pixel('{8'd200, 8'd200, 8'd100});
		add_pixel('{8'd50, 8'd150, 8'd100});   // right angle, green >= blue
		add_pixel('{8'd150, 8'd50, 8'd100});   // right angle, green < blue
		add_pixel('{8'd254, 8'd255, 8'd255});
		add_pixel('{8'd1, 8'd0, 8'd0});
		add_pixel('{8'd255, 8'd128, 8'd0});
		add_pixel('{8'd85, 8'd170, 8'd255});

		// Random pixels: mostly uniform, some gray, some near gray.
		for (int i = 0; i < 1232; i++) begin
			kind = $urandom_range(9);
			px = pixel_t'($urandom);
			if (kind == 0) begin
				px.green = px.red;
				px.blue = px.red;
			end else if (kind <= 2) begin
				px.green = 8'(px.red + $urandom_range(2) - 1);
				px.blue = 8'(px.red + $urandom_range(2) - 1);
			end
			add_pixel(px);
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// A stretch without gaps, then a full drain before going on.
		wait (pixel_q.size() < 900);
		idle_pct = 0;
		wait (pixel_q.size() < 600);
		idle_pct = 8;
		wait (pixel_q.size() < 300);
		drain_hold = 1'b1;
		@(posedge clk);
		wait (hsi_q.size() == 0);
		@(posedge clk);
		wait (hsi_q.size() == 0);
		drain_hold = 1'b0;

		wait (pixel_q.size() == 0);
		wait (hsi_q.size() == 0);
		repeat (30) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Timeout.
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ rgb_to_hsi_pixel.f @@
+incdir+rtl
rtl/hsi_pkg.sv
rtl/hsi_hue_search.sv
rtl/hsi_sat_div.sv
rtl/rgb_to_hsi_pixel.sv
dv/tb_rgb_to_hsi_pixel.sv
